// File: hw/rtl/gbn_pkg.sv
// gbn_pkg: shared types and constants of the go-back-n sender
// no dependencies; imported by the interfaces and every rtl module
`default_nettype none

package gbn_pkg;

	// input item kinds
	localparam logic [1:0] KIND_SEND = 2'd0;
	localparam logic [1:0] KIND_ACK  = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	// result kinds
	localparam logic [2:0] RK_SENT    = 3'd0;
	localparam logic [2:0] RK_RESENT  = 3'd1;
	localparam logic [2:0] RK_ACK_OK  = 3'd2;
	localparam logic [2:0] RK_ACK_BAD = 3'd3;
	localparam logic [2:0] RK_REFUSED = 3'd4;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;

	localparam logic [4:0]  WINDOW_RESET  = 5'd8;
	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

	// most resent segments per timeout
	localparam int unsigned RESULT_CAP = 16;

	// command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// width of the status count, enough for the largest window
	localparam int unsigned STAT_CNT_W = 7;

	typedef enum logic [1:0] {
		OP_SEND,
		OP_ACK,
		OP_TICK
	} gbn_op_t;

	typedef struct packed {
		gbn_op_t     op;
		logic [31:0] payload;
		logic [31:0] ack_number;
		logic        ack_check_ok;
	} gbn_cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_EMIT
	} gbn_back_state_t;

	typedef struct packed {
		logic [STAT_CNT_W-1:0] count;
		logic                  resending;
	} gbn_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/gbn_if.sv
// gbn_if: handshake channels of the go-back-n sender (items, results, config writes)
// depends on gbn_pkg for field widths
`default_nettype none

interface gbn_item_if
	import gbn_pkg::*;
	;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] payload;
	logic [31:0] ack_number;
	logic        ack_check_ok;

	modport source (output valid, kind, payload, ack_number, ack_check_ok, input ready);
	modport sink   (input valid, kind, payload, ack_number, ack_check_ok, output ready);
endinterface

interface gbn_result_if
	import gbn_pkg::*;
	;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [31:0] seq_number;
	logic [31:0] data_word;
	logic [4:0]  outstanding;
	logic        last;

	modport source (output valid, result_kind, seq_number, data_word, outstanding, last,
		input ready);
	modport sink   (input valid, result_kind, seq_number, data_word, outstanding, last,
		output ready);
endinterface

interface gbn_cfg_if
	import gbn_pkg::*;
	;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/go_back_n_sender.sv
// go_back_n_sender: top level of the go-back-n sender, front, command queue and back
// depends on gbn_pkg, gbn_if, gbn_front, gbn_queue and gbn_back
`default_nettype none

// Go-Back-N sender. Items arrive on the item channel: a new segment (kind 0), an
// acknowledgement (kind 1) or a timer tick (kind 2); kind 3 is dropped without a result.
// A segment is numbered, stored and reported as sent while fewer than window_size are
// unacknowledged, else it is refused and must be offered again. A checked ack between
// the base and the last number sent releases everything up to it. When the tick count
// reaches timeout_ticks all outstanding segments (at most 16) are resent, oldest first,
// with last set on the final one. The front registers and decodes each item into a
// two-entry command queue; the back executes one command at a time, so items flow at
// one per cycle while results are taken and no resend walk runs; a timeout passes each
// resent segment through a read state and an emit state, set by the registered read
// port of the segment store. The store has no reset and needs no clearing pass: only
// written entries are ever read. Configuration writes are always accepted (ready stays
// high) and must only be made while the block is idle.
module go_back_n_sender
	import gbn_pkg::*;
#(
	parameter int unsigned WINDOW_MAX = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	gbn_item_if.sink     item,
	gbn_result_if.source result,
	gbn_cfg_if.sink      cfg
);

	// front to queue
	gbn_cmd_t    f_cmd;
	logic        f_valid;
	logic        f_ready;

	// queue to back
	gbn_cmd_t    q_cmd;
	logic        q_valid;
	logic        q_pop;

	gbn_status_t st;

	// decode and register incoming transactions
	gbn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (f_cmd),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready)
	);

	// decouples the front from a back that is busy resending or stalled on results
	gbn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (f_cmd),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_cmd    (q_cmd),
		.pop_valid  (q_valid),
		.pop        (q_pop)
	);

	// window state, store, timer and output register
	gbn_back #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.cfg       (cfg),
		.result    (result),
		.status    (st)
	);

	// outstanding count never exceeds the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st.count <= STAT_CNT_W'(WINDOW_MAX))
		else $error("outstanding count beyond store depth");

	// a resend walk only runs with segments outstanding
	a_resend_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		st.resending |-> st.count != '0)
		else $error("resend walk with empty window");

	// a pending sent result implies a buffered segment
	a_sent_buffered: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.result_kind == RK_SENT) |-> st.count != '0)
		else $error("sent result without outstanding segment");

	// a retransmission is only offered during or right after a resend walk
	a_resent_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid && result.result_kind == RK_RESENT) |-> $past(st.resending))
		else $error("retransmission outside resend walk");

endmodule

`default_nettype wire

// File: hw/rtl/gbn_front.sv
// gbn_front: accepts input items, decodes the kind into a command, drops unknown kinds
// depends on gbn_pkg and gbn_item_if
`default_nettype none

module gbn_front
	import gbn_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	gbn_item_if.sink    item,
	output gbn_cmd_t    cmd,
	output logic        cmd_valid,
	input  wire logic   cmd_ready
);

	logic     valid_s1;
	gbn_cmd_t cmd_s1;
	logic     keep;
	gbn_op_t  op_dec;

	assign item.ready = !valid_s1 || cmd_ready;

	always_comb begin
		keep   = 1'b1;
		op_dec = OP_SEND;
		unique case (item.kind)
			KIND_SEND: op_dec = OP_SEND;
			KIND_ACK:  op_dec = OP_ACK;
			KIND_TICK: op_dec = OP_TICK;
			KIND_NONE: keep   = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			cmd_s1.op           <= op_dec;
			cmd_s1.payload      <= item.payload;
			cmd_s1.ack_number   <= item.ack_number;
			cmd_s1.ack_check_ok <= item.ack_check_ok;
		end
	end

	assign cmd       = cmd_s1;
	assign cmd_valid = valid_s1;

endmodule

`default_nettype wire

// File: hw/rtl/gbn_queue.sv
// gbn_queue: short command fifo between front and back
// depends on gbn_pkg
`default_nettype none

module gbn_queue
	import gbn_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  gbn_cmd_t  push_cmd,
	input  wire logic push_valid,
	output logic      push_ready,
	output gbn_cmd_t  pop_cmd,
	output logic      pop_valid,
	input  wire logic pop
);

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

	gbn_cmd_t        slots_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [FW-1:0]   fill_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = fill_q != FW'(QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_cmd    = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		bump = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= bump(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= bump(rd_ptr_q);
			if (do_push && !do_pop)      fill_q <= fill_q + FW'(1);
			else if (do_pop && !do_push) fill_q <= fill_q - FW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slots_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

// File: hw/rtl/gbn_back.sv
// gbn_back: window state, segment store, timer, resend walk and result register
// depends on gbn_pkg, gbn_result_if and gbn_cfg_if
`default_nettype none

module gbn_back
	import gbn_pkg::*;
#(
	parameter int unsigned WINDOW_MAX = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  gbn_cmd_t   cmd,
	input  wire logic  cmd_valid,
	output logic       cmd_pop,
	gbn_cfg_if.sink    cfg,
	gbn_result_if.source result,
	output gbn_status_t status
);

	localparam int unsigned IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
	localparam int unsigned SW = CW + 1;

	gbn_back_state_t state_q, state_d;

	logic [31:0]   base_q, next_q, elapsed_q, timeout_q;
	logic [4:0]    win_q;
	logic [IW-1:0] head_q;
	logic [CW-1:0] idx_q, nres_q;
	logic [31:0]   store_q [WINDOW_MAX];
	logic [31:0]   rdata_q;

	logic          out_valid_q;
	logic [2:0]    out_kind_q;
	logic [31:0]   out_seq_q, out_data_q;
	logic [4:0]    out_outs_q;
	logic          out_last_q;

	logic [CW-1:0] count, count_ack, rel, nres;
	logic [31:0]   eff_win, offset, el_inc, limit;
	logic          out_free, take, has_room, ack_ok, expire, emit_last;
	logic [IW-1:0] wr_slot, rd_slot, head_ack;

	logic          ld_out, mem_we, upd_send, upd_ack, tick_upd, tick_fire;
	logic [2:0]    o_kind;
	logic [31:0]   o_seq, o_data;
	logic [CW-1:0] o_outs;
	logic          o_last;

	function automatic logic [IW-1:0] wrap_idx(input logic [SW-1:0] s);
		wrap_idx = (s >= SW'(WINDOW_MAX)) ? IW'(s - SW'(WINDOW_MAX)) : IW'(s);
	endfunction

	assign cfg.ready = 1'b1;

	assign out_free  = !out_valid_q || result.ready;
	assign take      = (state_q == BK_IDLE) && cmd_valid && out_free;
	assign cmd_pop   = take;

	// window bookkeeping
	assign count     = CW'(next_q - base_q);
	assign eff_win   = (win_q == '0) ? 32'd1 :
		((32'(win_q) > 32'(WINDOW_MAX)) ? 32'(WINDOW_MAX) : 32'(win_q));
	assign has_room  = 32'(count) < eff_win;
	assign offset    = cmd.ack_number - base_q;
	assign ack_ok    = cmd.ack_check_ok && (offset < 32'(count));
	assign rel       = CW'(offset) + CW'(1);
	assign count_ack = count - rel;

	// timer
	assign el_inc    = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
	assign limit     = (timeout_q == '0) ? 32'd1 : timeout_q;
	assign expire    = el_inc >= limit;
	assign nres      = (32'(count) > 32'(RESULT_CAP)) ? CW'(RESULT_CAP) : count;
	assign emit_last = (idx_q + CW'(1)) == nres_q;

	assign wr_slot   = wrap_idx(SW'(head_q) + SW'(count));
	assign rd_slot   = wrap_idx(SW'(head_q) + SW'(idx_q));
	assign head_ack  = wrap_idx(SW'(head_q) + SW'(rel));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (take && cmd.op == OP_TICK && count != '0 && expire) state_d = BK_READ;
			end
			BK_READ: state_d = BK_EMIT;
			BK_EMIT: begin
				if (out_free) state_d = emit_last ? BK_IDLE : BK_READ;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		ld_out    = 1'b0;
		mem_we    = 1'b0;
		upd_send  = 1'b0;
		upd_ack   = 1'b0;
		tick_upd  = 1'b0;
		tick_fire = 1'b0;
		o_kind    = RK_SENT;
		o_seq     = base_q;
		o_data    = '0;
		o_outs    = count;
		o_last    = 1'b1;
		unique case (state_q)
			BK_IDLE: begin
				if (take) begin
					unique case (cmd.op)
						OP_SEND: begin
							ld_out = 1'b1;
							o_seq  = next_q;
							if (has_room) begin
								mem_we   = 1'b1;
								upd_send = 1'b1;
								o_kind   = RK_SENT;
								o_data   = cmd.payload;
								o_outs   = count + CW'(1);
							end else begin
								o_kind   = RK_REFUSED;
							end
						end
						OP_ACK: begin
							ld_out = 1'b1;
							if (ack_ok) begin
								upd_ack = 1'b1;
								o_kind  = RK_ACK_OK;
								o_seq   = cmd.ack_number + 32'd1;
								o_outs  = count_ack;
							end else begin
								o_kind  = RK_ACK_BAD;
							end
						end
						OP_TICK: begin
							if (count != '0) begin
								tick_fire = expire;
								tick_upd  = !expire;
							end
						end
						default: ;
					endcase
				end
			end
			BK_READ: ;
			BK_EMIT: begin
				if (out_free) begin
					ld_out = 1'b1;
					o_kind = RK_RESENT;
					o_seq  = base_q + 32'(idx_q);
					o_data = rdata_q;
					o_last = emit_last;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			base_q      <= '0;
			next_q      <= '0;
			elapsed_q   <= '0;
			head_q      <= '0;
			idx_q       <= '0;
			nres_q      <= '0;
			win_q       <= WINDOW_RESET;
			timeout_q   <= TIMEOUT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_WINDOW:  win_q     <= cfg.data[4:0];
					CFG_TIMEOUT: timeout_q <= cfg.data;
				endcase
			end
			if (upd_send) begin
				next_q <= next_q + 32'd1;
				if (count == '0) elapsed_q <= '0;
			end
			if (upd_ack) begin
				base_q <= cmd.ack_number + 32'd1;
				head_q <= head_ack;
				if (count_ack != '0) elapsed_q <= '0;
			end
			if (tick_upd) elapsed_q <= el_inc;
			if (tick_fire) begin
				elapsed_q <= '0;
				idx_q     <= '0;
				nres_q    <= nres;
			end
			if (state_q == BK_EMIT && out_free && !emit_last) idx_q <= idx_q + CW'(1);
			if (ld_out)            out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	// segment store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) store_q[wr_slot] <= cmd.payload;
		rdata_q <= store_q[rd_slot];
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_kind_q <= o_kind;
			out_seq_q  <= o_seq;
			out_data_q <= o_data;
			out_outs_q <= 5'(o_outs);
			out_last_q <= o_last;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.result_kind = out_kind_q;
	assign result.seq_number  = out_seq_q;
	assign result.data_word   = out_data_q;
	assign result.outstanding = out_outs_q;
	assign result.last        = out_last_q;

	assign status.count     = STAT_CNT_W'(count);
	assign status.resending = state_q != BK_IDLE;

endmodule

`default_nettype wire
